/* rtl/point_in_convex_brush_world_test_assert.svh */
// Assertion macros for the brush world test RTL
`ifndef POINT_IN_CONVEX_BRUSH_WORLD_TEST_ASSERT_SVH
`define POINT_IN_CONVEX_BRUSH_WORLD_TEST_ASSERT_SVH
`ifndef NO_ASSERTIONS
// antecedent implies consequent on the same edge
`define PCBW_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// expression must never hold
`define PCBW_ASSERT_NEVER(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error(msg);
`else
`define PCBW_ASSERT_IMPLY(lbl, ante, cons, msg)
`define PCBW_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

/* rtl/pcbw_pkg.sv */
// Package: sizes, codes and types of the brush world test
`timescale 1ns / 1ps
`default_nettype none
package pcbw_pkg;

   localparam int MAX_BRUSHES = 64;
   localparam int MAX_PLANES  = 8;
   localparam int BRUSH_W     = $clog2(MAX_BRUSHES);
   localparam int PLANE_W     = $clog2(MAX_PLANES);
   localparam int PADDR_W     = BRUSH_W + PLANE_W;
   localparam int PLANE_DEPTH = MAX_BRUSHES * MAX_PLANES;
   localparam int COUNT_W     = $clog2(MAX_PLANES + 1);
   localparam int LIMIT_W     = $clog2(MAX_BRUSHES + 1);
   localparam int COORD_W     = 32;

   // transaction modes
   localparam logic [1:0] MODE_WR_PLANE   = 2'd0;
   localparam logic [1:0] MODE_WR_HDR     = 2'd1;
   localparam logic [1:0] MODE_PT_QUERY   = 2'd2;
   localparam logic [1:0] MODE_AREA_QUERY = 2'd3;

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } vec3_type;

   typedef struct packed {
      vec3_type pos;
      vec3_type nrm;
   } plane_type;

   typedef struct packed {
      logic               active;
      logic [COUNT_W-1:0] count;
   } header_type;

   // one plane travelling down the evaluation pipe
   typedef struct packed {
      logic valid;
      logic last;
   } token_type;

   // verdict for one brush at the pipe tail
   typedef struct packed {
      logic valid;
      logic holds;
   } brush_res_type;

endpackage
`default_nettype wire

/* rtl/pcbw_plane_mem.sv */
// Plane store: position and normal per brush plane slot, registered read
`timescale 1ns / 1ps
`default_nettype none
module pcbw_plane_mem (
   input  wire logic                         clock,
   input  wire logic                         wr_en,
   input  wire logic [pcbw_pkg::PADDR_W-1:0] wr_addr,
   input  wire pcbw_pkg::plane_type          wr_data,
   input  wire logic                         rd_en,
   input  wire logic [pcbw_pkg::PADDR_W-1:0] rd_addr,
   output      pcbw_pkg::plane_type          rd_data
);
   import pcbw_pkg::*;

   plane_type mem_ff [PLANE_DEPTH];
   plane_type rd_data_ff;

   // single write port, single read port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* rtl/pcbw_hdr_mem.sv */
// Brush header store: active flag and plane count, valid bit per entry
`timescale 1ns / 1ps
`default_nettype none
module pcbw_hdr_mem (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         wr_en,
   input  wire logic [pcbw_pkg::BRUSH_W-1:0] wr_addr,
   input  wire pcbw_pkg::header_type         wr_data,
   input  wire logic                         rd_en,
   input  wire logic [pcbw_pkg::BRUSH_W-1:0] rd_addr,
   output      pcbw_pkg::header_type         rd_data
);
   import pcbw_pkg::*;

   header_type             mem_ff [MAX_BRUSHES];
   header_type             rd_data_ff;
   logic [MAX_BRUSHES-1:0] valid_ff;
   logic                   rd_valid_ff;

   // storage, no reset
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   // written flags: an unwritten entry reads as an inactive, empty brush
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule
`default_nettype wire

/* rtl/pcbw_plane_eval.sv */
// Plane side test pipeline: sign of dot((P - C) * 2^16 - N*H, N), ANDed per brush
`timescale 1ns / 1ps
`default_nettype none
module pcbw_plane_eval (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire pcbw_pkg::token_type    tok,
   input  wire pcbw_pkg::plane_type    plane,
   input  wire pcbw_pkg::vec3_type     query_p,
   input  wire pcbw_pkg::vec3_type     query_h,
   output      pcbw_pkg::brush_res_type res,
   output      logic                   busy
);
   import pcbw_pkg::*;

   coord_type p_w [3];
   coord_type h_w [3];
   coord_type c_w [3];
   coord_type n_w [3];

   // stage 1: difference and normal times half-size
   logic signed [COORD_W:0]     d1_in [3];
   logic signed [COORD_W:0]     d1_ff [3];
   logic signed [2*COORD_W-1:0] m1_in [3];
   logic signed [2*COORD_W-1:0] m1_ff [3];
   coord_type                   n1_ff [3];
   // stage 2: offset vector scaled by 2^16
   logic signed [2*COORD_W-1:0] v2_in [3];
   logic signed [2*COORD_W-1:0] v2_ff [3];
   coord_type                   n2_ff [3];
   // stage 3: low and high partial products
   logic signed [2*COORD_W-1:0] pl3_in [3];
   logic signed [2*COORD_W-1:0] pl3_ff [3];
   logic signed [2*COORD_W-1:0] ph3_in [3];
   logic signed [2*COORD_W-1:0] ph3_ff [3];
   // stage 4: full component products
   logic signed [3*COORD_W-1:0] prod4_in [3];
   logic signed [3*COORD_W-1:0] prod4_ff [3];
   // stage 5: partial sum
   logic signed [3*COORD_W:0]   sum5_in;
   logic signed [3*COORD_W:0]   sum5_ff;
   logic signed [3*COORD_W-1:0] rest5_ff;
   logic signed [3*COORD_W:0]   total;
   logic                        behind;

   token_type     tok1_ff, tok2_ff, tok3_ff, tok4_ff, tok5_ff;
   logic          all_ff, all_in;
   brush_res_type res_ff, res_in;

   assign p_w[0] = query_p.x;
   assign p_w[1] = query_p.y;
   assign p_w[2] = query_p.z;
   assign h_w[0] = query_h.x;
   assign h_w[1] = query_h.y;
   assign h_w[2] = query_h.z;
   assign c_w[0] = plane.pos.x;
   assign c_w[1] = plane.pos.y;
   assign c_w[2] = plane.pos.z;
   assign n_w[0] = plane.nrm.x;
   assign n_w[1] = plane.nrm.y;
   assign n_w[2] = plane.nrm.z;

   // datapath, one component per lane
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         d1_in[k]    = (COORD_W+1)'(p_w[k]) - (COORD_W+1)'(c_w[k]);
         m1_in[k]    = (2*COORD_W)'(n_w[k]) * (2*COORD_W)'(h_w[k]);
         v2_in[k]    = ((2*COORD_W)'(d1_ff[k]) <<< 16) - m1_ff[k];
         pl3_in[k]   = (2*COORD_W)'($signed({1'b0, v2_ff[k][COORD_W-1:0]}))
                       * (2*COORD_W)'(n2_ff[k]);
         ph3_in[k]   = (2*COORD_W)'($signed(v2_ff[k][2*COORD_W-1:COORD_W]))
                       * (2*COORD_W)'(n2_ff[k]);
         prod4_in[k] = ((3*COORD_W)'(ph3_ff[k]) <<< COORD_W)
                       + (3*COORD_W)'(pl3_ff[k]);
      end
      sum5_in = (3*COORD_W+1)'(prod4_ff[0]) + (3*COORD_W+1)'(prod4_ff[1]);
      total   = sum5_ff + (3*COORD_W+1)'(rest5_ff);
      behind  = total[3*COORD_W];
   end

   // payload pipeline registers
   always_ff @(posedge clock) begin
      d1_ff    <= d1_in;
      m1_ff    <= m1_in;
      n1_ff    <= n_w;
      v2_ff    <= v2_in;
      n2_ff    <= n1_ff;
      pl3_ff   <= pl3_in;
      ph3_ff   <= ph3_in;
      prod4_ff <= prod4_in;
      sum5_ff  <= sum5_in;
      rest5_ff <= prod4_ff[2];
   end

   // per-brush AND of the behind bits, verdict on the brush's last plane
   always_comb begin
      all_in = all_ff;
      res_in = '0;
      if (tok5_ff.valid) begin
         if (tok5_ff.last) begin
            res_in.valid = 1'b1;
            res_in.holds = all_ff & behind;
            all_in       = 1'b1;
         end else begin
            all_in = all_ff & behind;
         end
      end
   end

   // token and accumulator registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tok1_ff <= '0;
         tok2_ff <= '0;
         tok3_ff <= '0;
         tok4_ff <= '0;
         tok5_ff <= '0;
         all_ff  <= 1'b1;
         res_ff  <= '0;
      end else begin
         tok1_ff <= tok;
         tok2_ff <= tok1_ff;
         tok3_ff <= tok2_ff;
         tok4_ff <= tok3_ff;
         tok5_ff <= tok4_ff;
         all_ff  <= all_in;
         res_ff  <= res_in;
      end
   end

   assign res  = res_ff;
   assign busy = tok1_ff.valid | tok2_ff.valid | tok3_ff.valid | tok4_ff.valid
                 | tok5_ff.valid | res_ff.valid;

endmodule
`default_nettype wire

/* rtl/point_in_convex_brush_world_test.sv */
// Top level: brush world test, transaction sequencer and stores
//
// Request channel (req_*, valid/ready): mode 0 writes one plane, mode 1 a
// brush header; both complete in the cycle they are accepted and give no
// response. Modes 2 and 3 query a point (mode 3 first pushes each plane
// out by normal times half-size) and give one response on rsp_hit.
// Write port (csr_*): sets the number of brushes checked; always ready; the user
// must write it only while the block is idle, which the block does not enforce.
// A query walks brushes from index zero: a header read for each brush, then
// its planes issued in turn to the single plane store read port without
// waiting for the pipe (an inactive or empty brush issues none). Each plane
// passes the plane read, the test pipe and the verdict register; the walk
// stops at the next brush once a hit is in.
// Writes are accepted back to back; a query blocks new requests until its
// response is registered. A response waiting for rsp_ready does not stop the
// next request from being accepted; the following query holds its result
// until the output register is free.
// Reset clears brushes in use and all brush headers (inactive, no planes);
// plane slots are undefined until written.
`timescale 1ns / 1ps
`default_nettype none
`include "point_in_convex_brush_world_test_assert.svh"
module point_in_convex_brush_world_test (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output      logic                         req_ready,
   input  wire logic [1:0]                   req_mode,
   input  wire logic [pcbw_pkg::BRUSH_W-1:0] req_brush_index,
   input  wire logic [pcbw_pkg::PLANE_W-1:0] req_plane_index,
   input  wire pcbw_pkg::coord_type          req_pos_x,
   input  wire pcbw_pkg::coord_type          req_pos_y,
   input  wire pcbw_pkg::coord_type          req_pos_z,
   input  wire pcbw_pkg::coord_type          req_vec_x,
   input  wire pcbw_pkg::coord_type          req_vec_y,
   input  wire pcbw_pkg::coord_type          req_vec_z,
   input  wire logic                         req_active,
   input  wire logic [pcbw_pkg::COUNT_W-1:0] req_plane_count,
   output      logic                         rsp_valid,
   input  wire logic                         rsp_ready,
   output      logic                         rsp_hit,
   input  wire logic                         csr_valid,
   output      logic                         csr_ready,
   input  wire logic [pcbw_pkg::LIMIT_W-1:0] csr_brushes_in_use
);
   import pcbw_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_HDR   = 2'd1;
   localparam logic [1:0] ST_SCAN  = 2'd2;
   localparam logic [1:0] ST_DRAIN = 2'd3;

   logic [1:0]         state_ff, state_in;
   logic [LIMIT_W-1:0] brush_ff, brush_in;
   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic [LIMIT_W-1:0] in_use_ff;
   logic [LIMIT_W-1:0] limit_sat;
   logic [LIMIT_W-1:0] brush_next;
   logic [PLANE_W-1:0] plane_ff, plane_in;
   logic               hit_ff, hit_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_hit_ff, rsp_hit_in;
   vec3_type           query_p_ff, query_p_in;
   vec3_type           query_h_ff, query_h_in;
   token_type          tok_issue;
   token_type          tok_rd_ff;

   logic          req_accept;
   logic          is_query;
   logic          last_plane;
   logic          brush_done;
   logic          eval_busy;
   brush_res_type eval_res;
   header_type    hdr_rd;
   header_type    hdr_wr;
   plane_type     plane_wr;
   plane_type     plane_rd;
   vec3_type      req_pos;
   vec3_type      req_vec;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid & req_ready;
   assign is_query   = req_mode inside {MODE_PT_QUERY, MODE_AREA_QUERY};
   assign csr_ready  = 1'b1;

   assign req_pos = '{x: req_pos_x, y: req_pos_y, z: req_pos_z};
   assign req_vec = '{x: req_vec_x, y: req_vec_y, z: req_vec_z};

   // write data, plane count saturated at the slot count
   assign plane_wr = '{pos: req_pos, nrm: req_vec};
   always_comb begin
      hdr_wr.active = req_active;
      if (req_plane_count > COUNT_W'(MAX_PLANES)) begin
         hdr_wr.count = COUNT_W'(MAX_PLANES);
      end else begin
         hdr_wr.count = req_plane_count;
      end
   end

   assign limit_sat = (in_use_ff > LIMIT_W'(MAX_BRUSHES)) ? LIMIT_W'(MAX_BRUSHES)
                                                          : in_use_ff;
   assign brush_next = brush_ff + LIMIT_W'(1);
   assign brush_done = (brush_next == limit_ff);
   assign last_plane = (COUNT_W'(plane_ff) == (hdr_rd.count - COUNT_W'(1)));

   // stores; writes only happen while idle, reads only while walking
   pcbw_hdr_mem u_hdr_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (req_accept && (req_mode == MODE_WR_HDR)),
      .wr_addr (req_brush_index),
      .wr_data (hdr_wr),
      .rd_en   (state_ff == ST_HDR),
      .rd_addr (brush_ff[BRUSH_W-1:0]),
      .rd_data (hdr_rd)
   );

   pcbw_plane_mem u_plane_mem (
      .clock   (clock),
      .wr_en   (req_accept && (req_mode == MODE_WR_PLANE)),
      .wr_addr ({req_brush_index, req_plane_index}),
      .wr_data (plane_wr),
      .rd_en   (tok_issue.valid),
      .rd_addr ({brush_ff[BRUSH_W-1:0], plane_ff}),
      .rd_data (plane_rd)
   );

   pcbw_plane_eval u_plane_eval (
      .clock   (clock),
      .reset   (reset),
      .tok     (tok_rd_ff),
      .plane   (plane_rd),
      .query_p (query_p_ff),
      .query_h (query_h_ff),
      .res     (eval_res),
      .busy    (eval_busy)
   );

   // walk sequencer
   always_comb begin
      state_in     = state_ff;
      brush_in     = brush_ff;
      limit_in     = limit_ff;
      plane_in     = plane_ff;
      query_p_in   = query_p_ff;
      query_h_in   = query_h_ff;
      hit_in       = hit_ff | (eval_res.valid & eval_res.holds);
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_hit_in   = rsp_hit_ff;
      tok_issue    = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && is_query) begin
               query_p_in = req_pos;
               query_h_in = (req_mode == MODE_AREA_QUERY) ? req_vec : '0;
               brush_in   = '0;
               limit_in   = limit_sat;
               hit_in     = 1'b0;
               state_in   = (limit_sat == '0) ? ST_DRAIN : ST_HDR;
            end
         end
         ST_HDR: begin
            plane_in = '0;
            state_in = hit_ff ? ST_DRAIN : ST_SCAN;
         end
         ST_SCAN: begin
            if (!hdr_rd.active || (hdr_rd.count == '0)) begin
               // inactive brush is skipped, active empty brush holds everything
               if (hdr_rd.active) begin
                  hit_in = 1'b1;
               end
               brush_in = brush_next;
               state_in = brush_done ? ST_DRAIN : ST_HDR;
            end else begin
               tok_issue.valid = 1'b1;
               tok_issue.last  = last_plane;
               if (last_plane) begin
                  brush_in = brush_next;
                  state_in = brush_done ? ST_DRAIN : ST_HDR;
               end else begin
                  plane_in = plane_ff + PLANE_W'(1);
               end
            end
         end
         ST_DRAIN: begin
            if (!eval_busy && !tok_rd_ff.valid && (!rsp_valid_ff || rsp_ready)) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = hit_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         brush_ff     <= '0;
         limit_ff     <= '0;
         plane_ff     <= '0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         tok_rd_ff    <= '0;
         in_use_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         brush_ff     <= brush_in;
         limit_ff     <= limit_in;
         plane_ff     <= plane_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
         tok_rd_ff    <= tok_issue;
         if (csr_valid && csr_ready) begin
            in_use_ff <= csr_brushes_in_use;
         end
      end
   end

   // query and response payload
   always_ff @(posedge clock) begin
      query_p_ff <= query_p_in;
      query_h_ff <= query_h_in;
      rsp_hit_ff <= rsp_hit_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_hit   = rsp_hit_ff;

   `PCBW_ASSERT_IMPLY(a_idle_pipe_empty, state_ff == ST_IDLE, !eval_busy && !tok_rd_ff.valid, "plane pipe busy while idle")
   `PCBW_ASSERT_IMPLY(a_walk_in_range, state_ff == ST_HDR || state_ff == ST_SCAN, brush_ff < limit_ff, "brush counter past limit")
   `PCBW_ASSERT_NEVER(a_no_verdict_idle, eval_res.valid && state_ff == ST_IDLE, "brush verdict outside a query")
   `PCBW_ASSERT_IMPLY(a_rsp_from_drain, $rose(rsp_valid_ff), $past(state_ff) == ST_DRAIN, "response not loaded at end of walk")

endmodule
`default_nettype wire

/* tb/tb_point_in_convex_brush_world_test.sv */
// Testbench: brush world test, random brush tables checked against a hit predictor
`timescale 1ns / 1ps
module tb_point_in_convex_brush_world_test;
   import pcbw_pkg::*;

   localparam int STALL_LIMIT = 4000;
   localparam int TAIL_CYCLES = 700;
   localparam int IDLE_PCT    = 16;

   // one request transaction, every field at the port width
   typedef struct {
      logic [1:0]         mode;
      logic [BRUSH_W-1:0] brush;
      logic [PLANE_W-1:0] plane;
      vec3_type           pos;
      vec3_type           vec;
      logic               active;
      logic [COUNT_W-1:0] count;
   } brush_req_type;

   // shadow of the brush table plus the queue of hits still owed
   class brush_hit_ledger;
      vec3_type    plane_pos [MAX_BRUSHES][MAX_PLANES];
      vec3_type    plane_nrm [MAX_BRUSHES][MAX_PLANES];
      bit          brush_on [MAX_BRUSHES];
      int unsigned brush_planes [MAX_BRUSHES];
      int unsigned brush_limit;
      bit          hits_due [$];
      int unsigned fails;

      function void set_limit(int unsigned v);
         brush_limit = v;
      endfunction

      // exact sign of dot((P - C) * 2^16 - N * H, N)
      function bit behind_plane(vec3_type c, vec3_type n, vec3_type p, vec3_type h);
         coord_type           cc [3];
         coord_type           nn [3];
         coord_type           pp [3];
         coord_type           hh [3];
         logic signed [63:0]  pk, ck, nk, hk, lever;
         logic signed [127:0] wl, wn, dot;
         cc = '{c.x, c.y, c.z};
         nn = '{n.x, n.y, n.z};
         pp = '{p.x, p.y, p.z};
         hh = '{h.x, h.y, h.z};
         dot = '0;
         for (int k = 0; k < 3; k++) begin
            pk = 64'(pp[k]);
            ck = 64'(cc[k]);
            nk = 64'(nn[k]);
            hk = 64'(hh[k]);
            lever = (pk - ck) * 64'sd65536 - nk * hk;
            wl = 128'(lever);
            wn = 128'(nk);
            dot = dot + wl * wn;
         end
         return dot[127];
      endfunction

      // walk the brushes in use, stop at the first one holding the point
      function bit predict_hit(vec3_type p, vec3_type h);
         int unsigned lim;
         bit          in_b;
         lim = (brush_limit > MAX_BRUSHES) ? MAX_BRUSHES : brush_limit;
         for (int b = 0; b < lim; b++) begin
            if (brush_on[b]) begin
               in_b = 1'b1;
               for (int i = 0; i < brush_planes[b] && in_b; i++)
                  if (!behind_plane(plane_pos[b][i], plane_nrm[b][i], p, h))
                     in_b = 1'b0;
               if (in_b)
                  return 1'b1;
            end
         end
         return 1'b0;
      endfunction

      function void record_request(brush_req_type it);
         case (it.mode)
            MODE_WR_PLANE: begin
               plane_pos[it.brush][it.plane] = it.pos;
               plane_nrm[it.brush][it.plane] = it.vec;
            end
            MODE_WR_HDR: begin
               brush_on[it.brush]     = it.active;
               brush_planes[it.brush] = (it.count > MAX_PLANES) ? MAX_PLANES : it.count;
            end
            MODE_PT_QUERY: hits_due.push_back(predict_hit(it.pos, '0));
            default:       hits_due.push_back(predict_hit(it.pos, it.vec));
         endcase
      endfunction

      task report(string msg);
         $display("[%0t] hit mismatch: %s", $time, msg);
         fails++;
      endtask

      task check_hit(logic hit);
         bit due;
         if (hits_due.size() == 0) begin
            report($sformatf("response hit=%b with no query outstanding", hit));
         end else begin
            due = hits_due.pop_front();
            if (hit !== due)
               report($sformatf("hit=%b, predicted %b", hit, due));
         end
      endtask

      function int pending();
         return hits_due.size();
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_mode = MODE_WR_PLANE;
   logic [BRUSH_W-1:0] req_brush_index = '0;
   logic [PLANE_W-1:0] req_plane_index = '0;
   coord_type          req_pos_x = '0;
   coord_type          req_pos_y = '0;
   coord_type          req_pos_z = '0;
   coord_type          req_vec_x = '0;
   coord_type          req_vec_y = '0;
   coord_type          req_vec_z = '0;
   logic               req_active = 1'b0;
   logic [COUNT_W-1:0] req_plane_count = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_hit;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [LIMIT_W-1:0] csr_brushes_in_use = '0;

   brush_hit_ledger ledger = new();
   bit              calm = 1'b0;
   int unsigned     sent = 0;
   int unsigned     quiet_cycles = 0;
   bit              plane_written [MAX_BRUSHES][MAX_PLANES];

   always #10 clock = ~clock;

   point_in_convex_brush_world_test dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_mode           (req_mode),
      .req_brush_index    (req_brush_index),
      .req_plane_index    (req_plane_index),
      .req_pos_x          (req_pos_x),
      .req_pos_y          (req_pos_y),
      .req_pos_z          (req_pos_z),
      .req_vec_x          (req_vec_x),
      .req_vec_y          (req_vec_y),
      .req_vec_z          (req_vec_z),
      .req_active         (req_active),
      .req_plane_count    (req_plane_count),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_hit            (rsp_hit),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_brushes_in_use (csr_brushes_in_use)
   );

   // response side back-pressure
   always @(negedge clock)
      rsp_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);

   // response monitor
   always @(posedge clock)
      if (!reset && rsp_valid && rsp_ready)
         ledger.check_hit(rsp_hit);

   // watchdog: cycles with no transaction on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("tb_point_in_convex_brush_world_test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // planes 0.. written without a gap; header counts never reach past them
   function automatic int written_prefix(int b);
      int n;
      n = 0;
      while (n < MAX_PLANES && plane_written[b][n])
         n++;
      return n;
   endfunction

   function automatic brush_req_type noise_item();
      brush_req_type it;
      it.mode   = 2'($urandom);
      it.brush  = BRUSH_W'($urandom);
      it.plane  = PLANE_W'($urandom);
      it.pos    = {$urandom, $urandom, $urandom};
      it.vec    = {$urandom, $urandom, $urandom};
      it.active = 1'($urandom);
      it.count  = COUNT_W'($urandom);
      return it;
   endfunction

   // fields the mode ignores stay random
   function automatic brush_req_type make_req(logic [1:0] mode, int b, int p, vec3_type pos,
                                              vec3_type vec, logic act, int cnt);
      brush_req_type it;
      int            pre;
      it = noise_item();
      it.mode = mode;
      case (mode)
         MODE_WR_PLANE: begin
            it.brush = BRUSH_W'(b);
            it.plane = PLANE_W'(p);
            it.pos   = pos;
            it.vec   = vec;
         end
         MODE_WR_HDR: begin
            pre = written_prefix(b);
            it.brush  = BRUSH_W'(b);
            it.active = act;
            it.count  = COUNT_W'((pre < MAX_PLANES && cnt > pre) ? pre : cnt);
         end
         MODE_PT_QUERY: it.pos = pos;
         default: begin
            it.pos = pos;
            it.vec = vec;
         end
      endcase
      return it;
   endfunction

   task automatic send_req(brush_req_type it);
      @(negedge clock);
      while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_mode        <= it.mode;
      req_brush_index <= it.brush;
      req_plane_index <= it.plane;
      req_pos_x       <= it.pos.x;
      req_pos_y       <= it.pos.y;
      req_pos_z       <= it.pos.z;
      req_vec_x       <= it.vec.x;
      req_vec_y       <= it.vec.y;
      req_vec_z       <= it.vec.z;
      req_active      <= it.active;
      req_plane_count <= it.count;
      do @(posedge clock); while (!req_ready);
      ledger.record_request(it);
      if (it.mode == MODE_WR_PLANE)
         plane_written[it.brush][it.plane] = 1'b1;
      sent++;
   endtask

   // drop valid and wait for every owed response
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (ledger.pending() != 0)
         @(negedge clock);
   endtask

   task automatic write_limit(int unsigned v);
      drain();
      repeat (16) @(negedge clock);
      csr_valid          <= 1'b1;
      csr_brushes_in_use <= LIMIT_W'(v);
      do @(posedge clock); while (!csr_ready);
      ledger.set_limit(v);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // axis-aligned box around a random centre, then queries in and around it
   task automatic build_box(int b, int n, bit saturate);
      int             q [3];
      int             e [3];
      int             ci [3];
      int             ni [3];
      int             pt [3];
      int             hv [3];
      int             ax, ext, m, nq;
      logic [1:0]     mode;
      for (int k = 0; k < 3; k++) begin
         q[k] = int'($urandom_range(0, 32'h4000_0000)) - 32'h2000_0000;
         e[k] = int'($urandom_range(1, 32'h0400_0000));
      end
      for (int i = 0; i < n; i++) begin
         ax  = i % 3;
         ext = (i >= 6) ? 2 * e[ax] : e[ax];
         m   = $urandom_range(0, 1) ? 65536 : int'($urandom_range(1, 32'h7fff_ffff));
         ci  = q;
         ni  = '{0, 0, 0};
         // outward normals: + side first, then - side, spare planes looser
         if ((i / 3) % 2 == 1) begin
            ci[ax] = q[ax] - ext;
            ni[ax] = -m;
         end else begin
            ci[ax] = q[ax] + ext;
            ni[ax] = m;
         end
         send_req(make_req(MODE_WR_PLANE, b, i, {ci[0], ci[1], ci[2]},
                           {ni[0], ni[1], ni[2]}, 1'b0, 0));
      end
      send_req(make_req(MODE_WR_HDR, b, 0, '0, '0,
                        saturate || ($urandom_range(0, 99) < 85),
                        saturate ? int'($urandom_range(8, 15)) : n));
      nq = $urandom_range(1, 3);
      for (int j = 0; j < nq; j++) begin
         for (int k = 0; k < 3; k++) begin
            pt[k] = q[k] + int'($urandom_range(0, e[k])) - e[k] / 2;
            hv[k] = int'($urandom_range(0, 8192)) - 4096;
         end
         if (j > 0 && $urandom_range(0, 3) == 0)
            pt = '{$urandom, $urandom, $urandom};
         if ($urandom_range(0, 3) == 0)
            hv = '{$urandom, $urandom, $urandom};
         mode = (j > 0 && $urandom_range(0, 1)) ? MODE_AREA_QUERY : MODE_PT_QUERY;
         send_req(make_req(mode, 0, 0, {pt[0], pt[1], pt[2]}, {hv[0], hv[1], hv[2]},
                           1'b0, 0));
      end
   endtask

   initial begin
      int unsigned limits [6];
      int unsigned goal, lim, r, b, n;
      bit          paused;
      vec3_type    vmin, vmax, one;

      vmin = {3{32'h8000_0000}};
      vmax = {3{32'h7fff_ffff}};
      one  = {3{32'h0001_0000}};

      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // directed: no brushes in use, then an empty active brush holds everything
      write_limit(0);
      send_req(make_req(MODE_WR_HDR, 0, 0, '0, '0, 1'b1, 0));
      send_req(make_req(MODE_PT_QUERY, 0, 0, vmin, '0, 1'b0, 0));
      write_limit(1);
      send_req(make_req(MODE_PT_QUERY, 0, 0, vmin, '0, 1'b0, 0));
      send_req(make_req(MODE_AREA_QUERY, 0, 0, vmax, vmax, 1'b0, 0));
      // zero normal is never behind
      send_req(make_req(MODE_WR_PLANE, 0, 0, '0, '0, 1'b0, 0));
      send_req(make_req(MODE_WR_HDR, 0, 0, '0, '0, 1'b1, 1));
      send_req(make_req(MODE_PT_QUERY, 0, 0, one, '0, 1'b0, 0));
      // extreme plane: point far behind, then pushed in front by the half-size
      send_req(make_req(MODE_WR_PLANE, 0, 0, vmax, vmax, 1'b0, 0));
      send_req(make_req(MODE_PT_QUERY, 0, 0, vmin, '0, 1'b0, 0));
      send_req(make_req(MODE_AREA_QUERY, 0, 0, vmin, vmin, 1'b0, 0));
      // point on the plane is not strictly behind
      send_req(make_req(MODE_WR_PLANE, 0, 0, vmin, vmin, 1'b0, 0));
      send_req(make_req(MODE_PT_QUERY, 0, 0, vmin, '0, 1'b0, 0));
      send_req(make_req(MODE_WR_HDR, 0, 0, '0, '0, 1'b0, 0));
      // last brush, all eight planes, plane count saturating
      write_limit(MAX_BRUSHES);
      build_box(MAX_BRUSHES - 1, MAX_PLANES, 1'b1);

      // random phases over several brush limits, one without idling
      limits[0] = 127;
      limits[1] = MAX_BRUSHES;
      limits[2] = $urandom_range(1, 8);
      limits[3] = 40;
      limits[4] = $urandom_range(65, 126);
      limits[5] = $urandom_range(0, 127);
      for (int ph = 0; ph < 6; ph++) begin
         write_limit(limits[ph]);
         calm   = (ph == 3);
         goal   = sent + 75;
         paused = 1'b0;
         lim    = (limits[ph] > MAX_BRUSHES) ? MAX_BRUSHES : limits[ph];
         while (sent < goal) begin
            if (ph == 1 && !paused && sent + 40 >= goal) begin
               drain();
               paused = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (r < 55) begin
               b = (lim > 0 && $urandom_range(0, 9) != 0) ?
                   $urandom_range(0, lim - 1) : $urandom_range(0, MAX_BRUSHES - 1);
               n = $urandom_range(1, MAX_PLANES);
               build_box(b, n, n == MAX_PLANES && $urandom_range(0, 1));
            end else if (r < 68) begin
               send_req(make_req(MODE_WR_PLANE, $urandom_range(0, MAX_BRUSHES - 1),
                                 $urandom_range(0, MAX_PLANES - 1),
                                 {$urandom, $urandom, $urandom},
                                 {$urandom, $urandom, $urandom}, 1'b0, 0));
            end else if (r < 80) begin
               send_req(make_req(MODE_WR_HDR, $urandom_range(0, MAX_BRUSHES - 1), 0, '0, '0,
                                 $urandom_range(0, 1), $urandom_range(0, 15)));
            end else begin
               send_req(make_req($urandom_range(0, 1) ? MODE_AREA_QUERY : MODE_PT_QUERY,
                                 0, 0, {$urandom, $urandom, $urandom},
                                 {$urandom, $urandom, $urandom}, 1'b0, 0));
            end
         end
      end
      calm = 1'b0;

      drain();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (ledger.fails == 0)
         $display("tb_point_in_convex_brush_world_test passed");
      else
         $display("tb_point_in_convex_brush_world_test failed");
      $finish;
   end

endmodule

/* point_in_convex_brush_world_test.f */
+incdir+rtl
rtl/pcbw_pkg.sv
rtl/pcbw_plane_mem.sv
rtl/pcbw_hdr_mem.sv
rtl/pcbw_plane_eval.sv
rtl/point_in_convex_brush_world_test.sv
tb/tb_point_in_convex_brush_world_test.sv
